// ----- sv/bmrs_pkg.sv -----
// ----------------------------------------------------------------------------
// bmrs_pkg
// Shared types and constants for the bitmap range set/clear/find block.
// ----------------------------------------------------------------------------
package bmrs_pkg;

    localparam int unsigned IDX_W = 11;
    // internal position width: one more bit than an index, holds idx + 1
    localparam int unsigned POS_W = IDX_W + 1;

    typedef enum logic [2:0] {
        OP_SET_BIT   = 3'd0,
        OP_CLR_BIT   = 3'd1,
        OP_SET_RANGE = 3'd2,
        OP_CLR_RANGE = 3'd3,
        OP_GET_BIT   = 3'd4,
        OP_FIND_SET  = 3'd5,
        OP_FIND_CLR  = 3'd6
    } op_t;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [IDX_W-1:0] first_index;
        logic [IDX_W-1:0] stop_index;
    } cmd_t;

    typedef struct packed {
        logic             bit_value;
        logic [IDX_W-1:0] found_index;
    } rsp_t;

    // status from the word unit back to the sequencer
    typedef struct packed {
        logic we;
        logic hit;
        logic bit_value;
    } unit_stat_t;

endpackage

// ----- sv/bitmap_range_set_clear_find.sv -----
// ----------------------------------------------------------------------------
// bitmap_range_set_clear_find
// Bit array with single-bit and range set/clear, bit read and find-first
// set/clear, swept one word per cycle through a shared word unit.
// ----------------------------------------------------------------------------
// sequence: S_DIV finds the first word, S_BASE sets it up, S_RUN sweeps words to the last
//   or a find's match; empty ranges, out-of-range bits and opcode 7 strobe done from idle
// throughput: one item at a time, busy high from accept to the done strobe of a swept item;
//   a new item may be started in the strobe cycle; the receiver cannot stall
// reset: after rst_n the store is cleared one word per cycle, busy high until the last
//   word is cleared
module bitmap_range_set_clear_find #(
    parameter int unsigned NUM_BITS  = 1024,
    parameter int unsigned WORD_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  bmrs_pkg::cmd_t cmd,
    output logic           done,
    output bmrs_pkg::rsp_t rsp
);

    localparam int unsigned POS_W       = bmrs_pkg::POS_W;
    localparam int unsigned IDX_W       = bmrs_pkg::IDX_W;
    localparam int unsigned STORE_WORDS = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int unsigned OFF_W       = $clog2(WORD_BITS + 1);
    localparam int unsigned PW          = $clog2(WORD_BITS);
    // highest reachable bound: indices never exceed the index field
    localparam int unsigned LIM         = (NUM_BITS < (1 << IDX_W)) ? NUM_BITS : (1 << IDX_W);
    // reciprocal of the word size, exact quotient for every POS_W-bit value
    localparam int unsigned SH          = 24;
    localparam int unsigned RECIP_W     = 22;
    localparam longint unsigned RECIP   = ((64'd1 << SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned PROD_W      = POS_W + RECIP_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CLR  = 5'b00010,
        S_DIV  = 5'b00100,
        S_BASE = 5'b01000,
        S_RUN  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    bmrs_pkg::op_t       op_reg, op_next;
    logic [POS_W-1:0]    lo_reg, lo_next;
    logic [POS_W-1:0]    hi_reg, hi_next;
    logic [POS_W-1:0]    q_reg, q_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic [AW-1:0]       iss_word_reg, iss_word_next;
    logic [POS_W-1:0]    iss_base_reg, iss_base_next;
    logic                iss_done_reg, iss_done_next;
    logic                d_valid_reg, d_valid_next;
    logic [AW-1:0]       d_word_reg, d_word_next;
    logic [POS_W-1:0]    d_base_reg, d_base_next;
    logic                d_last_reg, d_last_next;
    logic                done_reg, done_next;
    bmrs_pkg::rsp_t      rsp_reg, rsp_next;

    logic [POS_W-1:0]    a_ext;
    logic [POS_W-1:0]    e_clamp;
    logic [PROD_W-1:0]   prod;
    logic [POS_W-1:0]    iss_base_inc;
    logic [POS_W-1:0]    lo_diff;
    logic [POS_W-1:0]    hi_diff;
    logic [OFF_W-1:0]    lo_off;
    logic [OFF_W-1:0]    hi_off;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] unit_wdata;
    logic [PW-1:0]        unit_pos;
    bmrs_pkg::unit_stat_t unit_stat;

    assign a_ext   = POS_W'(cmd.first_index);
    assign e_clamp = (POS_W'(cmd.stop_index) > POS_W'(LIM)) ? POS_W'(LIM)
                                                            : POS_W'(cmd.stop_index);
    assign prod    = PROD_W'(lo_reg) * PROD_W'(RECIP_W'(RECIP));
    assign iss_base_inc = iss_base_reg + POS_W'(WORD_BITS);

    // offsets of the range edges inside the word being processed
    assign lo_diff = lo_reg - d_base_reg;
    assign hi_diff = hi_reg - d_base_reg;
    assign lo_off  = (lo_reg > d_base_reg) ? OFF_W'(lo_diff) : '0;
    assign hi_off  = (hi_diff >= POS_W'(WORD_BITS)) ? OFF_W'(WORD_BITS) : OFF_W'(hi_diff);

    bmrs_word_unit #(
        .WORD_BITS (WORD_BITS)
    ) u_unit (
        .op     (op_reg),
        .rdata  (ram_rdata),
        .lo_off (lo_off),
        .hi_off (hi_off),
        .wdata  (unit_wdata),
        .pos    (unit_pos),
        .stat   (unit_stat)
    );

    always_comb
    begin
        if (state_reg == S_CLR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = (state_reg == S_RUN) && d_valid_reg && unit_stat.we;
            ram_waddr = d_word_reg;
            ram_wdata = unit_wdata;
        end
    end

    bmrs_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (iss_word_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        q_next        = q_reg;
        clr_next      = clr_reg;
        iss_word_next = iss_word_reg;
        iss_base_next = iss_base_reg;
        iss_done_next = iss_done_reg;
        d_valid_next  = 1'b0;
        d_word_next   = d_word_reg;
        d_base_next   = d_base_reg;
        d_last_next   = d_last_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;

        unique case (state_reg)
            S_CLR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(STORE_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = bmrs_pkg::op_t'(cmd.opcode);
                    lo_next  = a_ext;
                    rsp_next = '0;
                    case (cmd.opcode)
                        bmrs_pkg::OP_SET_BIT, bmrs_pkg::OP_CLR_BIT, bmrs_pkg::OP_GET_BIT:
                        begin
                            hi_next = a_ext + POS_W'(1);
                            if (a_ext >= POS_W'(LIM))
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_DIV;
                            end
                        end
                        bmrs_pkg::OP_SET_RANGE, bmrs_pkg::OP_CLR_RANGE,
                        bmrs_pkg::OP_FIND_SET, bmrs_pkg::OP_FIND_CLR:
                        begin
                            hi_next = e_clamp;
                            if (a_ext >= e_clamp)
                            begin
                                done_next = 1'b1;
                                if ((cmd.opcode == bmrs_pkg::OP_FIND_SET) ||
                                    (cmd.opcode == bmrs_pkg::OP_FIND_CLR))
                                begin
                                    rsp_next.found_index = IDX_W'(e_clamp);
                                end
                            end
                            else
                            begin
                                state_next = S_DIV;
                            end
                        end
                        default: done_next = 1'b1;
                    endcase
                end
            end
            S_DIV:
            begin
                q_next     = prod[SH +: POS_W];
                state_next = S_BASE;
            end
            S_BASE:
            begin
                iss_word_next = AW'(q_reg);
                iss_base_next = POS_W'(q_reg * POS_W'(WORD_BITS));
                iss_done_next = 1'b0;
                state_next    = S_RUN;
            end
            S_RUN:
            begin
                // read side: one word address per cycle
                if (!iss_done_reg)
                begin
                    d_valid_next  = 1'b1;
                    d_word_next   = iss_word_reg;
                    d_base_next   = iss_base_reg;
                    d_last_next   = (iss_base_inc >= hi_reg);
                    iss_done_next = (iss_base_inc >= hi_reg);
                    iss_word_next = iss_word_reg + AW'(1);
                    iss_base_next = iss_base_inc;
                end
                // data side: word read last cycle goes through the unit
                if (d_valid_reg)
                begin
                    if (op_reg == bmrs_pkg::OP_GET_BIT)
                    begin
                        rsp_next.bit_value = unit_stat.bit_value;
                    end
                    if (unit_stat.hit)
                    begin
                        rsp_next.found_index = IDX_W'(d_base_reg + POS_W'(unit_pos));
                    end
                    else if (d_last_reg &&
                             ((op_reg == bmrs_pkg::OP_FIND_SET) ||
                              (op_reg == bmrs_pkg::OP_FIND_CLR)))
                    begin
                        rsp_next.found_index = IDX_W'(hi_reg);
                    end
                    if (unit_stat.hit || d_last_reg)
                    begin
                        done_next    = 1'b1;
                        d_valid_next = 1'b0;
                        state_next   = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            clr_reg      <= '0;
            iss_done_reg <= 1'b1;
            d_valid_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            iss_done_reg <= iss_done_next;
            d_valid_reg  <= d_valid_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        q_reg        <= q_next;
        iss_word_reg <= iss_word_next;
        iss_base_reg <= iss_base_next;
        d_word_reg   <= d_word_next;
        d_base_reg   <= d_base_next;
        d_last_reg   <= d_last_next;
        rsp_reg      <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ----- sv/bmrs_ram.sv -----
// ----------------------------------------------------------------------------
// bmrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmrs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/bmrs_word_unit.sv -----
// ----------------------------------------------------------------------------
// bmrs_word_unit
// Shared word unit: builds the range mask for one word, applies set or
// clear, finds the first matching bit and picks out a single bit.
// ----------------------------------------------------------------------------
module bmrs_word_unit #(
    parameter int unsigned WORD_BITS = 32
) (
    input  bmrs_pkg::op_t                      op,
    input  logic [WORD_BITS-1:0]               rdata,
    input  logic [$clog2(WORD_BITS+1)-1:0]     lo_off,
    input  logic [$clog2(WORD_BITS+1)-1:0]     hi_off,
    output logic [WORD_BITS-1:0]               wdata,
    output logic [$clog2(WORD_BITS)-1:0]       pos,
    output bmrs_pkg::unit_stat_t               stat
);

    localparam int unsigned PW = $clog2(WORD_BITS);

    logic [WORD_BITS:0]   m_lo;
    logic [WORD_BITS:0]   m_hi;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] cand;
    logic [WORD_BITS-1:0] shifted;

    // thermometer masks, one bit wider so a shift by WORD_BITS empties them
    assign m_lo    = {(WORD_BITS+1){1'b1}} << lo_off;
    assign m_hi    = {(WORD_BITS+1){1'b1}} << hi_off;
    assign mask    = m_lo[WORD_BITS-1:0] & ~m_hi[WORD_BITS-1:0];
    assign shifted = rdata >> lo_off;

    always_comb
    begin
        wdata          = rdata;
        cand           = '0;
        stat.we        = 1'b0;
        stat.bit_value = shifted[0];
        case (op)
            bmrs_pkg::OP_SET_BIT, bmrs_pkg::OP_SET_RANGE:
            begin
                wdata   = rdata | mask;
                stat.we = 1'b1;
            end
            bmrs_pkg::OP_CLR_BIT, bmrs_pkg::OP_CLR_RANGE:
            begin
                wdata   = rdata & ~mask;
                stat.we = 1'b1;
            end
            bmrs_pkg::OP_FIND_SET: cand = rdata & mask;
            bmrs_pkg::OP_FIND_CLR: cand = ~rdata & mask;
            default: cand = '0;
        endcase
        stat.hit = |cand;
    end

    // priority encoder, lowest set bit wins
    always_comb
    begin
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                pos = PW'(i);
            end
        end
    end

endmodule

// ----- test/bitmap_range_set_clear_find_tb.sv -----
// ----------------------------------------------------------------------------
// bitmap_range_set_clear_find_tb
// Drives opcode/index items into the bitmap block and keeps a shadow copy of
// the bit array; every done strobe is checked against the oldest prediction.
// Directed cases cover the array edges and the clamping rules, then a random
// mix of single-bit, range and find items runs with and without sender gaps.
// ----------------------------------------------------------------------------
module bitmap_range_set_clear_find_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NUM_BITS  = 1024;
    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned IDX_W     = bmrs_pkg::IDX_W;
    localparam logic [2:0]  OP_UNUSED = 3'd7;
    localparam int          TAIL_CYCLES = 60;

    logic           clk   = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    bmrs_pkg::cmd_t cmd   = '0;
    logic           busy;
    logic           done;
    bmrs_pkg::rsp_t rsp;

    logic [NUM_BITS-1:0] shadow_bits = '0;
    bmrs_pkg::rsp_t      pending_rsp[$];
    int                  err_count = 0;

    bitmap_range_set_clear_find #(
        .NUM_BITS (NUM_BITS),
        .WORD_BITS(WORD_BITS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .cmd  (cmd),
        .done (done),
        .rsp  (rsp)
    );

    always #5 clk = ~clk;

    // updates the shadow array and returns what the block should answer
    function automatic bmrs_pkg::rsp_t apply_bitmap_cmd(bmrs_pkg::cmd_t c);
        bmrs_pkg::rsp_t r;
        int   lo;
        int   hi;
        logic want;
        r  = '0;
        lo = int'(c.first_index);
        hi = (c.stop_index > NUM_BITS) ? int'(NUM_BITS) : int'(c.stop_index);
        case (c.opcode)
            bmrs_pkg::OP_SET_BIT:
                if (lo < NUM_BITS)
                    shadow_bits[lo] = 1'b1;
            bmrs_pkg::OP_CLR_BIT:
                if (lo < NUM_BITS)
                    shadow_bits[lo] = 1'b0;
            bmrs_pkg::OP_SET_RANGE, bmrs_pkg::OP_CLR_RANGE:
                for (int i = lo; i < hi; i++)
                    shadow_bits[i] = (c.opcode == bmrs_pkg::OP_SET_RANGE);
            bmrs_pkg::OP_GET_BIT:
                if (lo < NUM_BITS)
                    r.bit_value = shadow_bits[lo];
            bmrs_pkg::OP_FIND_SET, bmrs_pkg::OP_FIND_CLR:
            begin
                want          = (c.opcode == bmrs_pkg::OP_FIND_SET);
                r.found_index = IDX_W'(hi);
                for (int i = lo; i < hi; i++)
                begin
                    if (shadow_bits[i] == want)
                    begin
                        r.found_index = IDX_W'(i);
                        break;
                    end
                end
            end
            default:
                ;
        endcase
        return r;
    endfunction

    // mostly in range, with edges and out-of-range values mixed in
    function automatic int random_index();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            return $urandom_range(1024, 2047);
        else if (pick < 12)
            case ($urandom_range(0, 4))
                0: return 0;
                1: return WORD_BITS - 1;
                2: return WORD_BITS;
                3: return NUM_BITS - 1;
                default: return NUM_BITS;
            endcase
        return $urandom_range(0, NUM_BITS - 1);
    endfunction

    function automatic bmrs_pkg::cmd_t random_cmd();
        bmrs_pkg::cmd_t c;
        int   pick;
        int   lo;
        int   hi;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            c.opcode = bmrs_pkg::OP_SET_BIT;
        else if (pick < 22)
            c.opcode = bmrs_pkg::OP_CLR_BIT;
        else if (pick < 36)
            c.opcode = bmrs_pkg::OP_SET_RANGE;
        else if (pick < 48)
            c.opcode = bmrs_pkg::OP_CLR_RANGE;
        else if (pick < 64)
            c.opcode = bmrs_pkg::OP_GET_BIT;
        else if (pick < 80)
            c.opcode = bmrs_pkg::OP_FIND_SET;
        else if (pick < 96)
            c.opcode = bmrs_pkg::OP_FIND_CLR;
        else
            c.opcode = OP_UNUSED;
        lo = random_index();
        case ($urandom_range(0, 19))
            0:       hi = random_index();
            1:       hi = $urandom_range(0, 2047);
            2:       hi = NUM_BITS;
            3:       hi = lo + $urandom_range(0, 1100);
            default: hi = lo + $urandom_range(0, 48);
        endcase
        if (hi > 2047)
            hi = 2047;
        c.first_index = IDX_W'(lo);
        c.stop_index  = IDX_W'(hi);
        return c;
    endfunction

    // holds start until the block takes the item, then records the prediction
    task automatic send_item(bmrs_pkg::cmd_t c);
        cmd   <= c;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        pending_rsp.push_back(apply_bitmap_cmd(c));
    endtask

    task automatic send_op(logic [2:0] op, int lo, int hi);
        bmrs_pkg::cmd_t c;
        c.opcode      = op;
        c.first_index = IDX_W'(lo);
        c.stop_index  = IDX_W'(hi);
        send_item(c);
    endtask

    task automatic sender_gap();
        int n;
        if ($urandom_range(0, 99) < 33)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    // array edges, word boundaries, clamping, reversed/empty ranges, unused op
    task automatic test_directed_cases();
        send_op(bmrs_pkg::OP_GET_BIT,   0,    0);
        send_op(bmrs_pkg::OP_FIND_SET,  0,    NUM_BITS);
        send_op(bmrs_pkg::OP_FIND_CLR,  0,    NUM_BITS);
        send_op(bmrs_pkg::OP_SET_BIT,   0,    0);
        send_op(bmrs_pkg::OP_SET_BIT,   1023, 0);
        send_op(bmrs_pkg::OP_SET_BIT,   1024, 2047);
        send_op(bmrs_pkg::OP_SET_BIT,   2047, 0);
        send_op(bmrs_pkg::OP_GET_BIT,   0,    2047);
        send_op(bmrs_pkg::OP_GET_BIT,   1023, 0);
        send_op(bmrs_pkg::OP_GET_BIT,   1024, 0);
        send_op(bmrs_pkg::OP_GET_BIT,   2047, 0);
        send_op(bmrs_pkg::OP_FIND_SET,  1,    2047);
        send_op(bmrs_pkg::OP_SET_RANGE, 0,    NUM_BITS);
        send_op(bmrs_pkg::OP_FIND_CLR,  0,    NUM_BITS);
        send_op(bmrs_pkg::OP_CLR_RANGE, 31,   33);
        send_op(bmrs_pkg::OP_FIND_CLR,  0,    NUM_BITS);
        send_op(bmrs_pkg::OP_FIND_SET,  31,   33);
        send_op(bmrs_pkg::OP_FIND_SET,  500,  100);
        send_op(bmrs_pkg::OP_CLR_RANGE, 600,  600);
        send_op(bmrs_pkg::OP_CLR_BIT,   1023, 0);
        send_op(bmrs_pkg::OP_FIND_CLR,  33,   2047);
        send_op(bmrs_pkg::OP_SET_RANGE, 1000, 2047);
        send_op(bmrs_pkg::OP_GET_BIT,   1023, 0);
        send_op(OP_UNUSED,              2047, 2047);
        send_op(bmrs_pkg::OP_CLR_RANGE, 0,    2047);
        send_op(bmrs_pkg::OP_FIND_SET,  2047, 2047);
        wait_all_results();
    endtask

    task automatic test_random_mix(int count, bit idle_en);
        for (int n = 0; n < count; n++)
        begin
            send_item(random_cmd());
            if (idle_en)
                sender_gap();
        end
    endtask

    // let the block drain completely, then resume from an idle block
    task automatic test_drain_then_resume();
        test_random_mix(30, 1'b0);
        wait_all_results();
        test_random_mix(30, 1'b1);
    endtask

    always @(posedge clk)
    begin
        bmrs_pkg::rsp_t exp_rsp;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("done strobe with no item outstanding");
                err_count++;
            end
            else
            begin
                exp_rsp = pending_rsp.pop_front();
                if (rsp.bit_value !== exp_rsp.bit_value)
                begin
                    $error("bit_value mismatch: expected %0d, got %0d",
                           exp_rsp.bit_value, rsp.bit_value);
                    err_count++;
                end
                if (rsp.found_index !== exp_rsp.found_index)
                begin
                    $error("found_index mismatch: expected %0d, got %0d",
                           exp_rsp.found_index, rsp.found_index);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_mix(550, 1'b1);
        test_random_mix(250, 1'b0);
        test_drain_then_resume();
        test_random_mix(450, 1'b1);
        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("bitmap_range_set_clear_find verification clean");
        else
            $display("bitmap_range_set_clear_find verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("bitmap_range_set_clear_find verification failed");
        $finish;
    end

endmodule

// ----- bitmap_range_set_clear_find.f -----
sv/bmrs_pkg.sv
sv/bmrs_ram.sv
sv/bmrs_word_unit.sv
sv/bitmap_range_set_clear_find.sv
test/bitmap_range_set_clear_find_tb.sv
